[rtl/assert_macros.svh]
// Assertion macros shared by the detector's modules.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/lpfd_pkg.sv]
// Types and constants of the laser pole feature detector.
// Used by lpfd_ctrl, lpfd_datapath and the top level; depends on nothing.
package lpfd_pkg;

  localparam int PI_FX      = 205887;
  localparam int TWO_PI_FX  = 411775;
  localparam int HALF_PI_FX = 102944;
  localparam int GAIN_FX    = 39797;
  localparam int TABLE_LEN  = 24;
  localparam int REDUCE_TOP = 10;

  localparam logic [2:0] REG_START_ANGLE = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
  localparam logic [2:0] REG_SAME_RANGE  = 3'd2;
  localparam logic [2:0] REG_POLE_RADIUS = 3'd3;
  localparam logic [2:0] REG_WIDTH_TOL   = 3'd4;
  localparam logic [2:0] REG_MAX_RANGE   = 3'd5;

  typedef struct packed {
    logic capture;
    logic commit_start;
    logic commit_grow;
    logic commit_end;
    logic vec_init;
    logic rot_init;
    logic cordic_step;
    logic bear_init;
    logic bear_reduce;
    logic bear_wrap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic grow;
    logic emit;
    logic it_last;
    logic it_zero;
    logic out_free;
  } stat_t;

  function automatic logic signed [19:0] atan_at(input logic [4:0] i);
    logic signed [19:0] t;
    case (i)
      5'd0:    t = 20'sd51472;
      5'd1:    t = 20'sd30385;
      5'd2:    t = 20'sd16055;
      5'd3:    t = 20'sd8150;
      5'd4:    t = 20'sd4091;
      5'd5:    t = 20'sd2047;
      5'd6:    t = 20'sd1024;
      5'd7:    t = 20'sd512;
      5'd8:    t = 20'sd256;
      5'd9:    t = 20'sd128;
      5'd10:   t = 20'sd64;
      5'd11:   t = 20'sd32;
      5'd12:   t = 20'sd16;
      5'd13:   t = 20'sd8;
      5'd14:   t = 20'sd4;
      5'd15:   t = 20'sd2;
      5'd16:   t = 20'sd1;
      default: t = 20'sd0;
    endcase
    return t;
  endfunction

  // round to whole mm and saturate to +-65535
  function automatic logic signed [16:0] clamp17(input logic signed [35:0] v);
    logic signed [35:0] t;
    logic signed [16:0] r;
    t = (v + 36'sd32768) >>> 16;
    if (t > 36'sd65535)
      r = 17'sd65535;
    else if (t < -36'sd65535)
      r = -17'sd65535;
    else
      r = 17'(t);
    return r;
  endfunction

endpackage

[rtl/lpfd_ctrl.sv]
// Sequencing state machine of the pole detector.
// Depends on lpfd_pkg and assert_macros.svh; drives lpfd_datapath by command.
`include "assert_macros.svh"

module lpfd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lpfd_pkg::stat_t st,
  output lpfd_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_VEC    = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_RED    = 4'd4;
  localparam logic [3:0] S_WRAP   = 4'd5;
  localparam logic [3:0] S_RINIT  = 4'd6;
  localparam logic [3:0] S_ROT    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.is_start) begin
          cmd.commit_start = 1'b1;
          state_next       = S_IDLE;
        end else if (st.grow) begin
          cmd.commit_grow = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.vec_init = 1'b1;
          state_next   = S_VEC;
        end
      end
      S_VEC: begin
        cmd.cordic_step = 1'b1;
        if (st.it_last) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.emit) begin
          cmd.bear_init = 1'b1;
          state_next    = S_RED;
        end else begin
          cmd.commit_end = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_RED: begin
        cmd.bear_reduce = 1'b1;
        if (st.it_zero) state_next = S_WRAP;
      end
      S_WRAP: begin
        cmd.bear_wrap = 1'b1;
        state_next    = S_RINIT;
      end
      S_RINIT: begin
        cmd.rot_init = 1'b1;
        state_next   = S_ROT;
      end
      S_ROT: begin
        cmd.cordic_step = 1'b1;
        if (st.it_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.commit_end = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  `ASSERT_NEXT(a_capture_decides, state == S_IDLE && in_valid, state == S_DECIDE, "capture not followed by decide")
  `ASSERT_ALWAYS(a_load_free, !cmd.out_load || st.out_free, "output loaded while full")
  `ASSERT_ALWAYS(a_one_commit, $onehot0({cmd.commit_start, cmd.commit_grow, cmd.commit_end}), "several commits")

endmodule

[rtl/lpfd_datapath.sv]
// Datapath: config registers, scan state, shared CORDIC, bearing reduction, output word.
// Depends on lpfd_pkg and assert_macros.svh; commanded by lpfd_ctrl.
`include "assert_macros.svh"

module lpfd_datapath #(
  parameter int COUNT_MAX = 4095,
  parameter int NSTEPS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [18:0]       cfg_data,
  input  logic [15:0]       in_range,
  input  logic              in_invalid,
  input  logic              in_start,
  input  lpfd_pkg::cmd_t    cmd,
  output lpfd_pkg::stat_t   st,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [87:0]       out_data
);

  logic signed [18:0] start_angle;
  logic [15:0]        angle_step, same_range_limit, pole_radius, max_feature_range;
  logic [17:0]        width_tolerance;

  logic [15:0] last_range, cur_range;
  logic        last_invalid, cur_invalid, cur_start;
  logic [23:0] segment_width;
  logic [11:0] sample_counter;

  logic signed [35:0] cx, cy;
  logic signed [19:0] cz;
  logic [4:0]         it;
  logic               vec_mode, rneg;
  logic signed [29:0] bear;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle       <= -19'sd205887;
      angle_step        <= 16'd643;
      same_range_limit  <= 16'd100;
      pole_radius       <= 16'd50;
      width_tolerance   <= 18'd3277;
      max_feature_range <= 16'd3000;
    end else if (cfg_we) begin
      case (cfg_index)
        lpfd_pkg::REG_START_ANGLE: start_angle       <= $signed(cfg_data);
        lpfd_pkg::REG_ANGLE_STEP:  angle_step        <= cfg_data[15:0];
        lpfd_pkg::REG_SAME_RANGE:  same_range_limit  <= cfg_data[15:0];
        lpfd_pkg::REG_POLE_RADIUS: pole_radius       <= cfg_data[15:0];
        lpfd_pkg::REG_WIDTH_TOL:   width_tolerance   <= cfg_data[17:0];
        lpfd_pkg::REG_MAX_RANGE:   max_feature_range <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // decision
  logic [16:0] rdiff, rabs;
  logic [24:0] wsum;
  logic [23:0] wsat;
  assign rdiff = {1'b0, cur_range} - {1'b0, last_range};
  assign rabs  = rdiff[16] ? (~rdiff + 17'd1) : rdiff;
  assign wsum  = {1'b0, segment_width} + {9'd0, angle_step};
  assign wsat  = wsum[24] ? 24'hFFFFFF : wsum[23:0];

  logic signed [25:0] werr, wabs;
  logic signed [19:0] zres;
  assign zres = (pole_radius == 16'd0) ? 20'sd0 : cz;
  assign werr = 26'(zres) - $signed({2'b00, segment_width});
  assign wabs = (werr < 0) ? -werr : werr;

  assign st.is_start = cur_start;
  assign st.grow     = !cur_invalid && !last_invalid && (rabs < {1'b0, same_range_limit});
  assign st.emit     = (wabs < $signed({8'd0, width_tolerance})) && !last_invalid &&
                       (last_range <= max_feature_range);
  assign st.it_last  = (it == 5'(NSTEPS - 1));
  assign st.it_zero  = (it == 5'd0);
  assign st.out_free = !out_valid || out_ready;

  // CORDIC step: x moves by y/2^i, y by x/2^i
  logic signed [35:0] dx, dy;
  logic signed [19:0] tab;
  logic               pos;
  assign dx  = cy >>> it;
  assign dy  = cx >>> it;
  assign tab = lpfd_pkg::atan_at(it);
  assign pos = vec_mode ? !(cy > 36'sd0) : (cz >= 20'sd0);

  // bearing
  logic [27:0]        prod;
  logic [29:0]        twopi_k;
  logic signed [29:0] bsub;
  logic [31:0]        rgain;
  assign prod    = sample_counter * angle_step;
  assign twopi_k = 30'(lpfd_pkg::TWO_PI_FX) << it;
  assign bsub    = bear - $signed(twopi_k);
  assign rgain   = last_range * 16'(lpfd_pkg::GAIN_FX);

  logic signed [35:0] xf, yf;
  assign xf = rneg ? -cx : cx;
  assign yf = rneg ? -cy : cy;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_range   <= in_range;
      cur_invalid <= in_invalid;
      cur_start   <= in_start;
    end
    if (cmd.vec_init) begin
      cx       <= $signed({4'd0, last_range, 16'd0});
      cy       <= $signed({4'd0, pole_radius, 16'd0});
      cz       <= 20'sd0;
      it       <= 5'd0;
      vec_mode <= 1'b1;
    end else if (cmd.rot_init) begin
      cx       <= $signed({4'd0, rgain});
      cy       <= 36'sd0;
      it       <= 5'd0;
      vec_mode <= 1'b0;
      if (bear > 30'(lpfd_pkg::HALF_PI_FX)) begin
        cz   <= 20'(bear - 30'(lpfd_pkg::PI_FX));
        rneg <= 1'b1;
      end else if (bear < -30'(lpfd_pkg::HALF_PI_FX)) begin
        cz   <= 20'(bear + 30'(lpfd_pkg::PI_FX));
        rneg <= 1'b1;
      end else begin
        cz   <= 20'(bear);
        rneg <= 1'b0;
      end
    end else if (cmd.cordic_step) begin
      it <= it + 5'd1;
      if (pos) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - tab;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + tab;
      end
    end else if (cmd.bear_init) begin
      bear <= 30'(start_angle) + $signed({2'b00, prod}) + 30'(lpfd_pkg::PI_FX);
      it   <= 5'(lpfd_pkg::REDUCE_TOP);
    end else if (cmd.bear_reduce) begin
      if (!bsub[29]) bear <= bsub;
      it <= it - 5'd1;
    end else if (cmd.bear_wrap) begin
      // negatives stay put: adding two pi and taking it off again cancel
      if (bear > 30'(lpfd_pkg::PI_FX)) bear <= bear - 30'(lpfd_pkg::TWO_PI_FX);
    end
    if (cmd.out_load) begin
      out_data <= {7'd0, lpfd_pkg::clamp17(yf), lpfd_pkg::clamp17(xf), 19'(bear),
                   last_range, sample_counter};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_range     <= 16'd0;
      last_invalid   <= 1'b1;
      segment_width  <= 24'd0;
      sample_counter <= 12'd0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.out_load)    out_valid <= 1'b1;
      else if (out_ready)  out_valid <= 1'b0;
      if (cmd.commit_start) begin
        last_range     <= cur_range;
        last_invalid   <= cur_invalid;
        segment_width  <= 24'd0;
        sample_counter <= 12'd0;
      end else if (cmd.commit_grow || cmd.commit_end) begin
        last_range    <= cur_range;
        last_invalid  <= cur_invalid;
        segment_width <= cmd.commit_grow ? wsat : 24'd0;
        if (sample_counter < 12'(COUNT_MAX)) sample_counter <= sample_counter + 12'd1;
      end
    end
  end

  `ASSERT_ALWAYS(a_count_sat, sample_counter <= 12'(COUNT_MAX), "sample counter past limit")
  `ASSERT_NEXT(a_bear_wrapped, cmd.bear_wrap, bear <= 30'(lpfd_pkg::PI_FX) && bear >= -30'(lpfd_pkg::PI_FX), "bearing not wrapped")

endmodule

[rtl/laser_pole_feature_detector.sv]
// Channel   Dir  Width  Content
// s_axis    in   16+2   range sample, invalid and scan start flags in tuser
// m_axis    out  88     pole feature word
// cfg       in   19     register writes, index 0..5
// A scan start or a growing sample passes only the decide state before ready returns.
// A segment end runs the CORDIC in vectoring mode; a reported pole also runs the
// shared iterative CORDIC a second time and the 11-step bearing reduction.
// One sample in flight; a held result stalls the emit step and with it acceptance.
// Reset is synchronous; no clearing pass.
// Top level; depends on lpfd_pkg, lpfd_ctrl and lpfd_datapath.
module laser_pole_feature_detector #(
  parameter int MAX_SAMPLES  = 4096,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // range_mm
  input  logic [1:0]  s_axis_tuser,   // invalid, scan_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // sample_number, pole_range, bearing, x_mm, y_mm
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [18:0] cfg_data
);

  localparam int COUNT_MAX = (MAX_SAMPLES - 1 > 4095) ? 4095 : MAX_SAMPLES - 1;
  localparam int NSTEPS    = (CORDIC_STEPS > lpfd_pkg::TABLE_LEN) ?
                             lpfd_pkg::TABLE_LEN : CORDIC_STEPS;

  lpfd_pkg::cmd_t  cmd;
  lpfd_pkg::stat_t st;

  lpfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lpfd_datapath #(
    .COUNT_MAX (COUNT_MAX),
    .NSTEPS    (NSTEPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_range   (s_axis_tdata),
    .in_invalid (s_axis_tuser[0]),
    .in_start   (s_axis_tuser[1]),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata)
  );

endmodule
